/* sv/rpv_pkg.sv */
// ----------------------------------------------------------------------------
// rpv_pkg
// Shared types, constants and the arctangent table for the rectangular /
// polar vector converter.
// ----------------------------------------------------------------------------
package rpv_pkg;

	localparam int ANG_W     = 32;
	localparam int FRAC_BITS = 16;
	localparam int GUARD     = 2;

	localparam logic [32:0] GAIN_INV     = 33'd2608131497;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] NEG_QUARTER  = 32'hC000_0000;

	typedef enum logic [1:0] {
		FORM_RECT  = 2'd0,
		FORM_POLAR = 2'd1
	} form_t;

	// per-request control travelling with the data
	typedef struct packed {
		logic valid;
		logic polar;
		logic bad;
		logic zero;
		logic a_neg;
		logic a_zero;
	} ctl_t;

	// atan(2^-i) in binary angle units, full turn = 2^32
	localparam logic [31:0] ARC_TABLE [32] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};

endpackage

/* sv/rpv_prep.sv */
// ----------------------------------------------------------------------------
// rpv_prep
// Gain prescale (stage 1) and quadrant pre-rotation (stage 2).
// ----------------------------------------------------------------------------
module rpv_prep import rpv_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int IW         = DATA_WIDTH + FRAC_BITS + GUARD
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [1:0]                   form_select,
	input  logic signed [DATA_WIDTH-1:0] first_value,
	input  logic signed [DATA_WIDTH-1:0] second_value,
	output ctl_t                         ctl_s2,
	output logic signed [IW-1:0]         x_s2,
	output logic signed [IW-1:0]         y_s2,
	output logic [ANG_W-1:0]             z_s2,
	output logic signed [DATA_WIDTH-1:0] a_s2,
	output logic signed [DATA_WIDTH-1:0] b_s2
);

	localparam int PW = DATA_WIDTH + 33;

	ctl_t                         ctl_in;
	ctl_t                         ctl_s1;
	logic signed [PW-1:0]         prod_a;
	logic signed [PW-1:0]         prod_b;
	logic signed [IW-1:0]         pa_s1;
	logic signed [IW-1:0]         pb_s1;
	logic signed [DATA_WIDTH-1:0] a_s1;
	logic signed [DATA_WIDTH-1:0] b_s1;
	logic signed [IW-1:0]         x_nx;
	logic signed [IW-1:0]         y_nx;
	logic [ANG_W-1:0]             z_nx;
	logic [ANG_W-1:0]             z_pol;
	logic                         flip;

	always_comb begin
		ctl_in.valid  = in_valid;
		ctl_in.polar  = (form_select == FORM_POLAR);
		ctl_in.bad    = (form_select != FORM_RECT) && (form_select != FORM_POLAR);
		ctl_in.zero   = (first_value == '0) && (second_value == '0);
		ctl_in.a_neg  = first_value[DATA_WIDTH-1];
		ctl_in.a_zero = (first_value == '0);
	end

	assign prod_a = PW'(first_value) * $signed(GAIN_INV);
	assign prod_b = PW'(second_value) * $signed(GAIN_INV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1 <= IW'($signed(prod_a[PW-1:ANG_W-FRAC_BITS]));
			pb_s1 <= IW'($signed(prod_b[PW-1:ANG_W-FRAC_BITS]));
			a_s1  <= first_value;
			b_s1  <= second_value;
		end
	end

	// angle in 32-bit units; sign bits of b fall off the top
	assign z_pol = ANG_W'(b_s1) << (ANG_W - DATA_WIDTH);
	assign flip  = z_pol[ANG_W-1] ? (z_pol < NEG_QUARTER) : (z_pol > QUARTER_TURN);

	always_comb begin
		if (ctl_s1.polar) begin
			x_nx = flip ? -pa_s1 : pa_s1;
			y_nx = '0;
			z_nx = flip ? z_pol + HALF_TURN : z_pol;
		end else if (pa_s1 < 0) begin
			x_nx = -pa_s1;
			y_nx = -pb_s1;
			z_nx = HALF_TURN;
		end else begin
			x_nx = pa_s1;
			y_nx = pb_s1;
			z_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= x_nx;
			y_s2 <= y_nx;
			z_s2 <= z_nx;
			a_s2 <= a_s1;
			b_s2 <= b_s1;
		end
	end

endmodule

/* sv/rpv_cell.sv */
// ----------------------------------------------------------------------------
// rpv_cell
// One micro-rotation: vectoring steers on y, rotation steers on z.
// ----------------------------------------------------------------------------
module rpv_cell import rpv_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int IW         = DATA_WIDTH + FRAC_BITS + GUARD,
	parameter int STAGE      = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  ctl_t                         ctl_in,
	input  logic signed [IW-1:0]         x_in,
	input  logic signed [IW-1:0]         y_in,
	input  logic [ANG_W-1:0]             z_in,
	input  logic signed [DATA_WIDTH-1:0] a_in,
	input  logic signed [DATA_WIDTH-1:0] b_in,
	output ctl_t                         ctl_q,
	output logic signed [IW-1:0]         x_q,
	output logic signed [IW-1:0]         y_q,
	output logic [ANG_W-1:0]             z_q,
	output logic signed [DATA_WIDTH-1:0] a_q,
	output logic signed [DATA_WIDTH-1:0] b_q
);

	localparam logic [ANG_W-1:0] ARC = ARC_TABLE[STAGE];

	logic signed [IW-1:0] xs;
	logic signed [IW-1:0] ys;
	logic                 ccw;

	assign xs  = x_in >>> STAGE;
	assign ys  = y_in >>> STAGE;
	assign ccw = ctl_in.polar ? !z_in[ANG_W-1] : y_in[IW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ccw) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ARC;
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ARC;
			end
			a_q <= a_in;
			b_q <= b_in;
		end
	end

endmodule

/* sv/rpv_post.sv */
// ----------------------------------------------------------------------------
// rpv_post
// Rounding, saturation and result select into the output register.
// ----------------------------------------------------------------------------
module rpv_post import rpv_pkg::*; #(
	parameter int DATA_WIDTH = 16,
	parameter int IW         = DATA_WIDTH + FRAC_BITS + GUARD
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  ctl_t                         ctl_in,
	input  logic signed [IW-1:0]         x_in,
	input  logic signed [IW-1:0]         y_in,
	input  logic [ANG_W-1:0]             z_in,
	input  logic signed [DATA_WIDTH-1:0] a_in,
	input  logic signed [DATA_WIDTH-1:0] b_in,
	output logic                         out_valid,
	output logic signed [DATA_WIDTH-1:0] x_out,
	output logic signed [DATA_WIDTH-1:0] y_out,
	output logic [DATA_WIDTH-1:0]        magnitude,
	output logic signed [DATA_WIDTH-1:0] angle,
	output logic                         mode_out,
	output logic                         bad_mode
);

	localparam int RW = IW - FRAC_BITS;
	localparam logic signed [IW-1:0] RND = IW'(1) <<< (FRAC_BITS - 1);
	localparam logic [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [IW-1:0]         xr_full;
	logic signed [IW-1:0]         yr_full;
	logic signed [RW-1:0]         xr;
	logic signed [RW-1:0]         yr;
	logic [DATA_WIDTH-1:0]        x_sat;
	logic [DATA_WIDTH-1:0]        y_sat;
	logic [DATA_WIDTH-1:0]        mag_v;
	logic [DATA_WIDTH-1:0]        ang_v;
	logic [DATA_WIDTH-1:0]        x_nx;
	logic [DATA_WIDTH-1:0]        y_nx;
	logic [DATA_WIDTH-1:0]        mag_nx;
	logic [DATA_WIDTH-1:0]        ang_nx;

	assign xr_full = x_in + RND;
	assign yr_full = y_in + RND;
	assign xr      = xr_full[IW-1:FRAC_BITS];
	assign yr      = yr_full[IW-1:FRAC_BITS];

	always_comb begin
		if (xr[RW-1:DATA_WIDTH-1] == '0 || xr[RW-1:DATA_WIDTH-1] == '1) begin
			x_sat = xr[DATA_WIDTH-1:0];
		end else begin
			x_sat = xr[RW-1] ? SMIN : SMAX;
		end
		if (yr[RW-1:DATA_WIDTH-1] == '0 || yr[RW-1:DATA_WIDTH-1] == '1) begin
			y_sat = yr[DATA_WIDTH-1:0];
		end else begin
			y_sat = yr[RW-1] ? SMIN : SMAX;
		end
		if (xr[RW-1]) begin
			mag_v = '0;
		end else if (xr[RW-2:DATA_WIDTH] != '0) begin
			mag_v = '1;
		end else begin
			mag_v = xr[DATA_WIDTH-1:0];
		end
	end

	generate
		if (DATA_WIDTH < ANG_W) begin : g_ang_rnd
			logic [ANG_W-1:0] z_rnd;
			assign z_rnd = z_in + (ANG_W'(1) << (ANG_W - 1 - DATA_WIDTH));
			assign ang_v = z_rnd[ANG_W-1 -: DATA_WIDTH];
		end else begin : g_ang_full
			assign ang_v = DATA_WIDTH'(z_in);
		end
	endgenerate

	always_comb begin
		if (ctl_in.bad) begin
			x_nx   = '0;
			y_nx   = '0;
			mag_nx = '0;
			ang_nx = '0;
		end else if (ctl_in.polar) begin
			x_nx   = x_sat;
			y_nx   = y_sat;
			mag_nx = ctl_in.a_neg ? DATA_WIDTH'(-a_in) : a_in;
			if (ctl_in.a_zero) begin
				ang_nx = '0;
			end else begin
				ang_nx = {b_in[DATA_WIDTH-1] ^ ctl_in.a_neg, b_in[DATA_WIDTH-2:0]};
			end
		end else begin
			x_nx   = a_in;
			y_nx   = b_in;
			mag_nx = mag_v;
			ang_nx = ctl_in.zero ? '0 : ang_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out     <= x_nx;
			y_out     <= y_nx;
			magnitude <= mag_nx;
			angle     <= ang_nx;
			mode_out  <= ctl_in.polar && !ctl_in.bad;
			bad_mode  <= ctl_in.bad;
		end
	end

endmodule

/* sv/rect_polar_vector_converter.sv */
// Registers from the accepting edge to result valid: prescale multiply, quadrant
// pre-rotation, one cell per micro-rotation, output.
// Throughput: one request per cycle; the whole pipeline holds while a result
// is stalled at the output register.
// Reset: arst_n clears all valid flags asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
// rect_polar_vector_converter
// CORDIC rectangular/polar converter built as a chain of rotation cells.
// ----------------------------------------------------------------------------
module rect_polar_vector_converter import rpv_pkg::*; #(
	parameter int DATA_WIDTH      = 16,
	parameter int ROTATION_STAGES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   form_select,
	input  logic signed [DATA_WIDTH-1:0] first_value,
	input  logic signed [DATA_WIDTH-1:0] second_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] x_out,
	output logic signed [DATA_WIDTH-1:0] y_out,
	output logic [DATA_WIDTH-1:0]        magnitude,
	output logic signed [DATA_WIDTH-1:0] angle,
	output logic                         mode_out,
	output logic                         bad_mode
);

	localparam int IW = DATA_WIDTH + FRAC_BITS + GUARD;
	localparam int NS = ROTATION_STAGES;

	logic                         en;
	ctl_t                         ctl_c [NS+1];
	logic signed [IW-1:0]         x_c   [NS+1];
	logic signed [IW-1:0]         y_c   [NS+1];
	logic [ANG_W-1:0]             z_c   [NS+1];
	logic signed [DATA_WIDTH-1:0] a_c   [NS+1];
	logic signed [DATA_WIDTH-1:0] b_c   [NS+1];

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	rpv_prep #(
		.DATA_WIDTH(DATA_WIDTH),
		.IW(IW)
	) u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.form_select(form_select),
		.first_value(first_value),
		.second_value(second_value),
		.ctl_s2(ctl_c[0]),
		.x_s2(x_c[0]),
		.y_s2(y_c[0]),
		.z_s2(z_c[0]),
		.a_s2(a_c[0]),
		.b_s2(b_c[0])
	);

	generate
		for (genvar i = 0; i < NS; i++) begin : g_cell
			rpv_cell #(
				.DATA_WIDTH(DATA_WIDTH),
				.IW(IW),
				.STAGE(i)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.en(en),
				.ctl_in(ctl_c[i]),
				.x_in(x_c[i]),
				.y_in(y_c[i]),
				.z_in(z_c[i]),
				.a_in(a_c[i]),
				.b_in(b_c[i]),
				.ctl_q(ctl_c[i+1]),
				.x_q(x_c[i+1]),
				.y_q(y_c[i+1]),
				.z_q(z_c[i+1]),
				.a_q(a_c[i+1]),
				.b_q(b_c[i+1])
			);
		end
	endgenerate

	rpv_post #(
		.DATA_WIDTH(DATA_WIDTH),
		.IW(IW)
	) u_post (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.ctl_in(ctl_c[NS]),
		.x_in(x_c[NS]),
		.y_in(y_c[NS]),
		.z_in(z_c[NS]),
		.a_in(a_c[NS]),
		.b_in(b_c[NS]),
		.out_valid(out_valid),
		.x_out(x_out),
		.y_out(y_out),
		.magnitude(magnitude),
		.angle(angle),
		.mode_out(mode_out),
		.bad_mode(bad_mode)
	);

endmodule

/* sv/rpv_checker.sv */
// ----------------------------------------------------------------------------
// rpv_checker
// Port-level assertions for the rectangular/polar vector converter.
// ----------------------------------------------------------------------------
module rpv_checker #(
	parameter int DATA_WIDTH = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [DATA_WIDTH-1:0] x_out,
	input logic signed [DATA_WIDTH-1:0] y_out,
	input logic [DATA_WIDTH-1:0]        magnitude,
	input logic signed [DATA_WIDTH-1:0] angle,
	input logic                         mode_out,
	input logic                         bad_mode
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(x_out) && $stable(y_out)
			&& $stable(magnitude) && $stable(angle))
		else $error("result changed while stalled");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled with free output");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_mode |-> !mode_out && x_out == '0 && y_out == '0
			&& magnitude == '0 && angle == '0)
		else $error("invalid form result not zeroed");

	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mode_out && !bad_mode && x_out == '0 && y_out == '0
			|-> magnitude == '0 && angle == '0)
		else $error("zero vector gave nonzero polar view");

endmodule

bind rect_polar_vector_converter rpv_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_rpv_checker (.*);

/* dv/tb_rect_polar_vector_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_polar_vector_converter
// Self-checking bench for the CORDIC rectangular/polar converter. A bit-exact
// predictor computes x, y, magnitude and angle for every accepted request and
// the monitor checks the results in order. Directed corner cases come first,
// then random requests under several sender/receiver idle mixes, including a
// long output hold that backs the pipeline up to its input.
// ----------------------------------------------------------------------------
module tb_rect_polar_vector_converter;
	import rpv_pkg::*;

	localparam int          DW          = 16;
	localparam int          STAGES      = 16;
	localparam int          LATENCY     = STAGES + 3;
	localparam int          STUCK_LIMIT = 2000;
	localparam longint      K_GAIN      = 64'sd2608131497;
	localparam logic [31:0] TURN_HALF   = 32'h8000_0000;
	localparam logic [31:0] TURN_QTR    = 32'h4000_0000;
	localparam logic [31:0] TURN_NQTR   = 32'hC000_0000;
	localparam logic [1:0]  FORM_BAD_2  = 2'd2;
	localparam logic [1:0]  FORM_BAD_3  = 2'd3;

	typedef struct packed {
		logic [1:0]          form;
		logic signed [DW-1:0] first;
		logic signed [DW-1:0] second;
	} conv_req_t;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic [DW-1:0]        mag;
		logic signed [DW-1:0] ang;
		logic                 mode;
		logic                 bad;
	} vec_result_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic [1:0]           form_select  = '0;
	logic signed [DW-1:0] first_value  = '0;
	logic signed [DW-1:0] second_value = '0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic signed [DW-1:0] x_out;
	logic signed [DW-1:0] y_out;
	logic [DW-1:0]        magnitude;
	logic signed [DW-1:0] angle;
	logic                 mode_out;
	logic                 bad_mode;

	conv_req_t   req_q[$];
	vec_result_t expected_q[$];
	conv_req_t   cur_req;
	vec_result_t want;
	int          n_accepted    = 0;
	int          n_errors      = 0;
	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	int          hold_left     = 0;
	bit          hold_done     = 1'b0;
	int          stuck_cycles  = 0;

	rect_polar_vector_converter #(
		.DATA_WIDTH      (DW),
		.ROTATION_STAGES (STAGES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.form_select  (form_select),
		.first_value  (first_value),
		.second_value (second_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.x_out        (x_out),
		.y_out        (y_out),
		.magnitude    (magnitude),
		.angle        (angle),
		.mode_out     (mode_out),
		.bad_mode     (bad_mode)
	);

	always #5 clk = ~clk;

	// atan(2^-i), full turn = 2^32
	function automatic logic [31:0] atan_step(input int i);
		case (i)
		0:  return 32'h20000000;
		1:  return 32'h12E4051D;
		2:  return 32'h09FB385B;
		3:  return 32'h051111D4;
		4:  return 32'h028B0D43;
		5:  return 32'h0145D7E1;
		6:  return 32'h00A2F61E;
		7:  return 32'h00517C55;
		8:  return 32'h0028BE53;
		9:  return 32'h00145F2E;
		10: return 32'h000A2F98;
		11: return 32'h000517CC;
		12: return 32'h00028BE6;
		13: return 32'h000145F3;
		14: return 32'h0000A2F9;
		15: return 32'h0000517C;
		default: return 32'h0;
		endcase
	endfunction

	function automatic longint gain_scale(input longint v);
		return (v * K_GAIN) >>> 16;
	endfunction

	function automatic longint round_guard(input longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic logic [DW-1:0] sat_word(input longint v);
		if (v > 32767)
			return 16'h7FFF;
		if (v < -32768)
			return 16'h8000;
		return v[DW-1:0];
	endfunction

	function automatic void vec_mag_angle(input longint x0, input longint y0,
			output logic [DW-1:0] mag, output logic [DW-1:0] ang);
		longint      x;
		longint      y;
		longint      t;
		logic [31:0] z;
		x = gain_scale(x0);
		y = gain_scale(y0);
		z = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = TURN_HALF;
		end
		for (int i = 0; i < STAGES; i++) begin
			if (y >= 0) begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z = z + atan_step(i);
			end else begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z = z - atan_step(i);
			end
			x = t;
		end
		t = round_guard(x);
		if (t < 0)
			t = 0;
		if (t > 65535)
			t = 65535;
		mag = t[DW-1:0];
		z = z + 32'h0000_8000;
		ang = (x0 == 0 && y0 == 0) ? '0 : z[31:16];
	endfunction

	function automatic void rot_xy(input longint m, input logic [31:0] z_in,
			output logic [DW-1:0] xo, output logic [DW-1:0] yo);
		longint      x;
		longint      y;
		longint      t;
		logic [31:0] z;
		x = gain_scale(m);
		y = 0;
		z = z_in;
		if (z[31] ? (z < TURN_NQTR) : (z > TURN_QTR)) begin
			x = -x;
			z = z + TURN_HALF;
		end
		for (int i = 0; i < STAGES; i++) begin
			if (!z[31]) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z = z - atan_step(i);
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z = z + atan_step(i);
			end
			x = t;
		end
		xo = sat_word(round_guard(x));
		yo = sat_word(round_guard(y));
	endfunction

	function automatic vec_result_t convert_request(input conv_req_t r);
		vec_result_t e;
		longint      a;
		longint      b;
		longint      m;
		e = '0;
		a = r.first;
		b = r.second;
		case (r.form)
		FORM_RECT: begin
			e.x = r.first;
			e.y = r.second;
			vec_mag_angle(a, b, e.mag, e.ang);
		end
		FORM_POLAR: begin
			rot_xy(a, {r.second, 16'h0000}, e.x, e.y);
			m = (a < 0) ? -a : a;
			e.mag = m[DW-1:0];
			if (a == 0)
				e.ang = '0;
			else if (a < 0)
				e.ang = r.second + 16'h8000;
			else
				e.ang = r.second;
			e.mode = 1'b1;
		end
		default: begin
			e.bad = 1'b1;
		end
		endcase
		return e;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			form_select  <= '0;
			first_value  <= '0;
			second_value <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				expected_q.push_back(convert_request(cur_req));
				n_accepted <= n_accepted + 1;
			end
			if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_req = req_q.pop_front();
				in_valid     <= 1'b1;
				form_select  <= cur_req.form;
				first_value  <= cur_req.first;
				second_value <= cur_req.second;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor and output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: result with nothing pending: x=%0d y=%0d mag=%0d ang=%0d",
							x_out, y_out, magnitude, angle);
				end else begin
					want = expected_q.pop_front();
					if (x_out !== want.x || y_out !== want.y || magnitude !== want.mag ||
							angle !== want.ang || mode_out !== want.mode ||
							bad_mode !== want.bad) begin
						n_errors++;
						if (n_errors <= 10)
							$display(
		"ERROR: x/y/mag/ang/mode/bad exp %0d/%0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0d/%0b/%0b",
								want.x, want.y, want.mag, want.ang, want.mode, want.bad,
								x_out, y_out, magnitude, angle, mode_out, bad_mode);
					end
				end
			end
			// one long hold so the pipeline backs up to the input
			if (!hold_done && n_accepted >= 300) begin
				hold_done <= 1'b1;
				hold_left <= 80;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("rect_polar_vector_converter: mismatch");
				$finish;
			end
		end
	end

	task automatic add_req(input logic [1:0] form, input logic [DW-1:0] a,
			input logic [DW-1:0] b);
		conv_req_t r;
		r.form   = form;
		r.first  = a;
		r.second = b;
		req_q.push_back(r);
	endtask

	function automatic logic [DW-1:0] rand_word();
		case ($urandom_range(9))
		0:       return 16'h8000;
		1:       return 16'h7FFF;
		2:       return 16'h0000;
		3:       return $urandom_range(1) ? 16'($urandom_range(7)) : -16'($urandom_range(8));
		default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_phase(input int s_idle, input int r_stall, input int n);
		int          k;
		logic [1:0]  form;
		send_idle_pct = s_idle;
		stall_pct     = r_stall;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(19);
			if (k < 9)
				form = FORM_RECT;
			else if (k < 18)
				form = FORM_POLAR;
			else
				form = $urandom_range(1) ? FORM_BAD_2 : FORM_BAD_3;
			add_req(form, rand_word(), rand_word());
		end
		while (req_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// rectangular corners: zero vector, axes, negative x on the axis
		add_req(FORM_RECT, 16'sd0, 16'sd0);
		add_req(FORM_RECT, 16'sd32767, 16'sd0);
		add_req(FORM_RECT, -16'sd32768, 16'sd0);
		add_req(FORM_RECT, -16'sd1, 16'sd0);
		add_req(FORM_RECT, 16'sd0, 16'sd32767);
		add_req(FORM_RECT, 16'sd0, -16'sd32768);
		add_req(FORM_RECT, -16'sd32768, -16'sd32768);
		add_req(FORM_RECT, 16'sd32767, 16'sd32767);
		add_req(FORM_RECT, -16'sd32768, 16'sd32767);
		add_req(FORM_RECT, -16'sd1, -16'sd1);
		add_req(FORM_RECT, 16'sd1, 16'sd1);
		// polar corners: zero and negative magnitude, quarter and half turns
		add_req(FORM_POLAR, 16'sd0, 16'sd12345);
		add_req(FORM_POLAR, 16'sd32767, 16'sd0);
		add_req(FORM_POLAR, 16'sd32767, 16'sd16384);
		add_req(FORM_POLAR, 16'sd32767, 16'sd16385);
		add_req(FORM_POLAR, 16'sd32767, -16'sd16384);
		add_req(FORM_POLAR, 16'sd32767, -16'sd16385);
		add_req(FORM_POLAR, 16'sd32767, -16'sd32768);
		add_req(FORM_POLAR, -16'sd32768, 16'sd0);
		add_req(FORM_POLAR, -16'sd32768, -16'sd32768);
		add_req(FORM_POLAR, 16'sd1000, 16'sd8192);
		add_req(FORM_POLAR, -16'sd1, 16'sd100);
		// invalid forms
		add_req(FORM_BAD_2, 16'sd1234, -16'sd4321);
		add_req(FORM_BAD_3, -16'sd1, -16'sd1);

		run_phase(0, 0, 300);
		run_phase(65, 0, 300);
		run_phase(0, 65, 300);
		run_phase(31, 31, 300);

		while (in_valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		if (n_errors == 0)
			$display("rect_polar_vector_converter: match");
		else
			$display("rect_polar_vector_converter: mismatch");
		$finish;
	end

endmodule
